// ----- hdl/cstm_pkg.sv -----
// ----------------------------------------------------------------------------
// cstm_pkg
// Shared types and constants for the critical section time monitor.
// ----------------------------------------------------------------------------
package cstm_pkg;

    // Table geometry
    localparam int NUM_TASKS  = 16;
    localparam int DEPTH_BITS = 8;
    localparam int TASK_BITS  = (NUM_TASKS > 2) ? $clog2(NUM_TASKS) : 1;

    localparam logic [31:0] THRESHOLD_RESET = 32'd1000;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // Event commands
    localparam logic CMD_DISABLE = 1'b0;
    localparam logic CMD_ENABLE  = 1'b1;

    // Input item
    typedef struct packed {
        logic        command;
        logic [7:0]  task_index;
        logic        in_isr;
        logic [31:0] now_ms;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic        ignored;
        logic        underflow;
        logic        overflow;
        logic [7:0]  nest_depth;
        logic        section_closed;
        logic [31:0] elapsed_ms;
        logic [31:0] high_water_ms;
        logic        new_high;
        logic        too_long;
    } out_item_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic eval;
        logic commit;
    } dp_cmd_t;

    // Low eight bits of a depth value, zero-extended when narrower
    function automatic logic [7:0] depth_to_out(input logic [DEPTH_BITS-1:0] d);
        logic [DEPTH_BITS+7:0] tmp;
        tmp = {8'd0, d};
        return tmp[7:0];
    endfunction

endpackage

// ----- hdl/cstm_ctrl.sv -----
// ----------------------------------------------------------------------------
// cstm_ctrl
// Sequencer: accepts an item, runs the read and write steps, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module cstm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output cstm_pkg::dp_cmd_t dp_cmd
);
    import cstm_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // State and result flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        dp_cmd         = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    dp_cmd.load_in = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                dp_cmd.eval = 1'b1;
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                // wait until the result register is free
                if (!out_valid_reg || !out_stall)
                begin
                    dp_cmd.commit  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/cstm_datapath.sv -----
// ----------------------------------------------------------------------------
// cstm_datapath
// Per-task depth, start time and high-water tables, threshold register and
// result register.
// ----------------------------------------------------------------------------
module cstm_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  cstm_pkg::dp_cmd_t dp_cmd,
    input  cstm_pkg::in_item_t in_item,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_data,
    output cstm_pkg::out_item_t out_item
);
    import cstm_pkg::*;

    // Tables
    logic [DEPTH_BITS-1:0] depth_tab_reg [NUM_TASKS];
    logic [31:0]           start_tab_reg [NUM_TASKS];
    logic [31:0]           mark_tab_reg  [NUM_TASKS];

    logic [31:0] threshold_reg;

    // Captured item and read-step results
    in_item_t              item_reg;
    logic                  ok_reg;
    logic [TASK_BITS-1:0]  slot_reg;
    logic [DEPTH_BITS-1:0] depth_rd_reg;
    logic [31:0]           mark_rd_reg;
    logic [31:0]           elapsed_reg;

    out_item_t             out_reg, out_next;

    logic                  idx_ok;
    logic [TASK_BITS-1:0]  slot_in;
    logic [8:0]            idx_wide;

    // Write-step results
    logic [DEPTH_BITS-1:0] depth_new;
    logic                  start_we;
    logic                  mark_we;

    // Index check
    assign idx_wide = {1'b0, in_item.task_index};
    assign idx_ok   = !in_item.in_isr && (in_item.task_index != 8'd0)
                      && (idx_wide < 9'(NUM_TASKS));
    assign slot_in  = in_item.task_index[TASK_BITS-1:0];

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESHOLD_RESET;
        else if (cfg_we)
            threshold_reg <= cfg_data;
    end

    // Item capture and table read
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_in)
        begin
            item_reg <= in_item;
            ok_reg   <= idx_ok;
            slot_reg <= slot_in;
        end
        if (dp_cmd.eval)
        begin
            depth_rd_reg <= depth_tab_reg[slot_reg];
            mark_rd_reg  <= mark_tab_reg[slot_reg];
            elapsed_reg  <= item_reg.now_ms - start_tab_reg[slot_reg];
        end
    end

    // Event evaluation
    always_comb
    begin
        out_next  = '0;
        depth_new = depth_rd_reg;
        start_we  = 1'b0;
        mark_we   = 1'b0;
        if (!ok_reg)
        begin
            out_next.ignored = 1'b1;
        end
        else
        begin
            if (item_reg.command == CMD_DISABLE)
            begin
                start_we = (depth_rd_reg == '0);
                if (depth_rd_reg == DEPTH_MAX)
                    out_next.overflow = 1'b1;
                else
                    depth_new = depth_rd_reg + 1'b1;
            end
            else
            begin
                if (depth_rd_reg == '0)
                begin
                    out_next.underflow = 1'b1;
                end
                else
                begin
                    depth_new = depth_rd_reg - 1'b1;
                    if (depth_rd_reg == DEPTH_BITS'(1))
                    begin
                        out_next.section_closed = 1'b1;
                        out_next.elapsed_ms     = elapsed_reg;
                        if (elapsed_reg > mark_rd_reg)
                        begin
                            mark_we           = 1'b1;
                            out_next.new_high = 1'b1;
                            out_next.too_long = (elapsed_reg > threshold_reg);
                        end
                    end
                end
            end
            out_next.nest_depth    = depth_to_out(depth_new);
            out_next.high_water_ms = mark_we ? elapsed_reg : mark_rd_reg;
        end
    end

    // Depth and high-water tables, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                depth_tab_reg[i] <= '0;
                mark_tab_reg[i]  <= '0;
            end
        end
        else if (dp_cmd.commit && ok_reg)
        begin
            depth_tab_reg[slot_reg] <= depth_new;
            if (mark_we)
                mark_tab_reg[slot_reg] <= elapsed_reg;
        end
    end

    // Start time table, written before its value is ever used
    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit && ok_reg && start_we)
            start_tab_reg[slot_reg] <= item_reg.now_ms;
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.commit)
            out_reg <= out_next;
    end

    assign out_item = out_reg;

endmodule

// ----- hdl/critical_section_time_monitor_top.sv -----
// ----------------------------------------------------------------------------
// critical_section_time_monitor_top
// Tracks nested interrupt-disable sections per task and reports depth,
// closed-section duration and high-water mark for every valid event; other events are only flagged as ignored.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    in_item  (command, task, isr flag, time)
//  out      out_valid / out_stall  out_item (flags, depth, elapsed, mark)
//  cfg      cfg_valid / cfg_ready  cfg_data (too-long threshold, ms)
//
//  Each item passes through capture, table read with subtract, then
//  compare and table write-back, sequenced by the controller.
//  A finished result waits in the output register; the next item is taken
//  meanwhile and stalls only in its write step if that register is full.
//  Reset clears the depth and high-water tables at once; the threshold
//  returns to 1000 ms. cfg_ready is always high.
// ----------------------------------------------------------------------------
module critical_section_time_monitor_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cstm_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output cstm_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);
    import cstm_pkg::*;

    dp_cmd_t dp_cmd;

    assign cfg_ready = 1'b1;

    // Sequencer
    cstm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    // Tables and arithmetic
    cstm_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .dp_cmd   (dp_cmd),
        .in_item  (in_item),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .out_item (out_item)
    );

endmodule
